@@ sv/bfs_pkg.sv @@
// Shared types and constants for the blocking flow-shop sequencer.
// Used by the row unit, the top level and the testbench; no dependencies.
package bfs_pkg;

  localparam int DEF_MAX_JOBS     = 32;
  localparam int DEF_MAX_MACHINES = 16;
  localparam int DEF_TIME_BITS    = 16;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 6;

  localparam logic [CFG_INDEX_BITS-1:0] REG_JOB_COUNT     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MACHINE_COUNT = 2'd1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  typedef struct packed {
    logic        command;
    logic [4:0]  job_index;
    logic [3:0]  machine_index;
    logic [15:0] proc_time;
    logic        use_start_job;
    logic [4:0]  start_job;
  } cmd_t;

  typedef struct packed {
    logic [4:0]  position;
    logic [4:0]  job;
    logic [31:0] makespan;
    logic        last;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS_START,
    S_RD,
    S_EX,
    S_END
  } state_t;

  typedef enum logic [1:0] {
    M_TOT,
    M_PL,
    M_CAND,
    M_CM
  } mode_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLR,
    OP_SUM,
    OP_INIT,
    OP_EXT
  } row_op_t;

  typedef struct packed {
    row_op_t op;
    logic    wr;
    logic    k_last;
  } row_ctl_t;

endpackage

@@ sv/bfs_time_mem.sv @@
// Processing-time table: one write port and one read port with registered data.
// Depends on nothing but its parameters.
module bfs_time_mem #(
  parameter int AW = 9,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/bfs_row_unit.sv @@
// Shared arithmetic unit: one machine step of a total-time sum, a first-job
// departure row or a blocking departure extension with its sigma. Uses bfs_pkg.
module bfs_row_unit
  import bfs_pkg::*;
#(
  parameter int MAX_MACHINES = DEF_MAX_MACHINES,
  parameter int TIME_BITS    = DEF_TIME_BITS,
  parameter int DW           = 42,
  parameter int SW           = 47,
  parameter int KW           = 5
) (
  input  logic                 clk,
  input  row_ctl_t             ctl,
  input  logic [KW-1:0]        k,
  input  logic [TIME_BITS-1:0] p,
  output logic [DW-1:0]        acc,
  output logic [SW-1:0]        sigma,
  output logic [DW-1:0]        last_val
);

  logic [DW-1:0] dep [0:MAX_MACHINES];
  logic [DW-1:0] cand;
  logic [DW-1:0] dep_k;
  logic [DW-1:0] p_ext;
  logic [DW-1:0] sum_val;
  logic [DW-1:0] acc_sum;
  logic [DW-1:0] nb;
  logic [DW-1:0] c_val;
  logic [KW-1:0] nb_idx;

  always_comb begin
    p_ext   = DW'(p);
    acc_sum = acc + p_ext;
    sum_val = cand + p_ext;
    nb_idx  = ctl.k_last ? k : k + KW'(1);
    nb      = ctl.k_last ? '0 : dep[nb_idx];
    if (ctl.k_last || sum_val > nb) begin
      c_val = sum_val;
    end else begin
      c_val = nb;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_CLR: begin
        acc <= '0;
      end
      OP_SUM: begin
        acc      <= acc_sum;
        last_val <= acc_sum;
        if (ctl.wr) begin
          dep[k] <= acc_sum;
        end
      end
      OP_INIT: begin
        cand  <= dep[1];
        dep_k <= dep[1];
        sigma <= '0;
      end
      OP_EXT: begin
        sigma    <= sigma + SW'(c_val - dep_k - p_ext);
        dep_k    <= nb;
        cand     <= c_val;
        last_val <= c_val;
        if (ctl.wr) begin
          dep[k] <= c_val;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sv/blocking_flowshop_pf_sequencer.sv @@
// Blocking flow-shop sequencer (profile fitting); uses bfs_pkg, bfs_time_mem, bfs_row_unit.
// A load is written while busy is low. A run first evaluates the total time of every job
// to pick the first job unless a valid start job is given, then places that job; each later
// position evaluates every unscheduled job, skipping scheduled ones, then commits the best.
// Each result strobes for one cycle and the receiver cannot stall.
// Synchronous active-high reset returns to idle with default counts.
module blocking_flowshop_pf_sequencer
  import bfs_pkg::*;
#(
  parameter int MAX_JOBS     = DEF_MAX_JOBS,
  parameter int MAX_MACHINES = DEF_MAX_MACHINES,
  parameter int TIME_BITS    = DEF_TIME_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  cmd_t                      cmd,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output logic                      result_valid,
  output rsp_t                      result
);

  localparam int JW  = $clog2(MAX_JOBS);
  localparam int KW  = $clog2(MAX_MACHINES + 1);
  localparam int AW  = $clog2(MAX_JOBS * MAX_MACHINES);
  localparam int DW  = TIME_BITS + $clog2(MAX_JOBS * MAX_MACHINES) + 1;
  localparam int SW  = DW + $clog2(MAX_MACHINES + 1);
  localparam int JCW = ($clog2(MAX_JOBS + 1) > 6) ? $clog2(MAX_JOBS + 1) : 6;
  localparam int MCW = ($clog2(MAX_MACHINES + 1) > 5) ? $clog2(MAX_MACHINES + 1) : 5;

  state_t state, state_next;
  mode_t  mode;
  row_ctl_t ctl;

  logic [JCW-1:0]      job_count;
  logic [MCW-1:0]      machine_count;
  logic [JW-1:0]       n_m1;
  logic [KW-1:0]       m_k;
  logic [JW-1:0]       j;
  logic [KW-1:0]       k;
  logic [JW-1:0]       pos;
  logic [JW-1:0]       best_j;
  logic [SW-1:0]       best_v;
  logic [MAX_JOBS-1:0] mask;
  logic [SW-1:0]       cmp_val;
  logic                better;
  logic [JW-1:0]       chosen;
  logic                run_acc;
  logic                load_ok;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  logic [TIME_BITS-1:0] rdata;
  logic [DW-1:0]       acc;
  logic [SW-1:0]       sigma;
  logic [DW-1:0]       last_val;
  logic [31:0]         span;

  always_comb begin
    if (32'(job_count) == 0) begin
      n_m1 = '0;
    end else if (32'(job_count) > MAX_JOBS) begin
      n_m1 = JW'(MAX_JOBS - 1);
    end else begin
      n_m1 = JW'(32'(job_count) - 1);
    end
    if (32'(machine_count) == 0) begin
      m_k = KW'(1);
    end else if (32'(machine_count) > MAX_MACHINES) begin
      m_k = KW'(MAX_MACHINES);
    end else begin
      m_k = KW'(machine_count);
    end
  end

  assign busy    = (state != S_IDLE);
  assign run_acc = start && !busy && (cmd.command == CMD_RUN);
  assign load_ok = start && !busy && (cmd.command == CMD_LOAD) &&
                   (32'(cmd.job_index) < MAX_JOBS) &&
                   (32'(cmd.machine_index) < MAX_MACHINES);
  assign waddr   = AW'(32'(cmd.job_index) * MAX_MACHINES + 32'(cmd.machine_index));
  assign raddr   = AW'(32'(j) * MAX_MACHINES + 32'(k) - 1);

  bfs_time_mem #(.AW(AW), .DW(TIME_BITS)) u_mem (
    .clk   (clk),
    .we    (load_ok),
    .waddr (waddr),
    .wdata (TIME_BITS'(cmd.proc_time)),
    .raddr (raddr),
    .rdata (rdata)
  );

  bfs_row_unit #(
    .MAX_MACHINES (MAX_MACHINES),
    .TIME_BITS    (TIME_BITS),
    .DW           (DW),
    .SW           (SW),
    .KW           (KW)
  ) u_row (
    .clk      (clk),
    .ctl      (ctl),
    .k        (k),
    .p        (rdata),
    .acc      (acc),
    .sigma    (sigma),
    .last_val (last_val)
  );

  assign cmp_val = (mode == M_TOT) ? SW'(acc) : sigma;
  assign better  = cmp_val < best_v;
  assign chosen  = better ? j : best_j;
  assign span    = (64'(last_val) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(last_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '{op: OP_NONE, wr: 1'b0, k_last: (k == m_k)};
    case (state)
      S_IDLE: begin
        if (run_acc) begin
          state_next = S_PASS_START;
        end
      end
      S_PASS_START: begin
        case (mode)
          M_TOT, M_PL: begin
            ctl.op     = OP_CLR;
            state_next = S_RD;
          end
          M_CAND: begin
            if (!mask[j]) begin
              ctl.op     = OP_INIT;
              state_next = S_RD;
            end
          end
          default: begin
            ctl.op     = OP_INIT;
            state_next = S_RD;
          end
        endcase
      end
      S_RD: begin
        state_next = S_EX;
      end
      S_EX: begin
        ctl.op     = (mode == M_TOT || mode == M_PL) ? OP_SUM : OP_EXT;
        ctl.wr     = (mode == M_PL || mode == M_CM);
        state_next = (k == m_k) ? S_END : S_RD;
      end
      S_END: begin
        state_next = S_PASS_START;
        if (mode == M_PL && n_m1 == '0) begin
          state_next = S_IDLE;
        end
        if (mode == M_CM && pos == n_m1) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_count     <= JCW'(MAX_JOBS);
      machine_count <= MCW'(MAX_MACHINES);
      result_valid  <= 1'b0;
      mode          <= M_TOT;
      mask          <= '0;
      best_v        <= '1;
      best_j        <= '0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_we && cfg_index == REG_JOB_COUNT) begin
        job_count <= JCW'(cfg_data);
      end
      if (cfg_we && cfg_index == REG_MACHINE_COUNT) begin
        machine_count <= MCW'(cfg_data[4:0]);
      end
      case (state)
        S_IDLE: begin
          if (run_acc) begin
            best_v <= '1;
            best_j <= '0;
            if (cmd.use_start_job && 32'(cmd.start_job) <= 32'(n_m1)) begin
              mode <= M_PL;
              j    <= JW'(cmd.start_job);
            end else begin
              mode <= M_TOT;
              j    <= '0;
            end
          end
        end
        S_PASS_START: begin
          k <= KW'(1);
          if (mode == M_CAND && mask[j]) begin
            if (j == n_m1) begin
              mode <= M_CM;
              j    <= best_j;
            end else begin
              j <= j + JW'(1);
            end
          end
        end
        S_EX: begin
          if (k != m_k) begin
            k <= k + KW'(1);
          end
        end
        S_END: begin
          case (mode)
            M_TOT, M_CAND: begin
              if (better) begin
                best_v <= cmp_val;
                best_j <= j;
              end
              if (j == n_m1) begin
                mode <= (mode == M_TOT) ? M_PL : M_CM;
                j    <= chosen;
              end else begin
                j <= j + JW'(1);
              end
            end
            default: begin
              result_valid    <= 1'b1;
              result.position <= (mode == M_PL) ? 5'd0 : 5'(pos);
              result.job      <= 5'(j);
              mask            <= ((mode == M_PL) ? '0 : mask) | (MAX_JOBS'(1) << j);
              if ((mode == M_PL && n_m1 == '0) || (mode == M_CM && pos == n_m1)) begin
                result.last     <= 1'b1;
                result.makespan <= span;
              end else begin
                result.last     <= 1'b0;
                result.makespan <= '0;
                pos             <= (mode == M_PL) ? JW'(1) : pos + JW'(1);
                mode            <= M_CAND;
                j               <= '0;
                best_v          <= '1;
                best_j          <= '0;
              end
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result strobe without a run in progress");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> !busy)
    else $error("run still busy after its last result");

  a_makespan_only_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> result.makespan == 32'd0)
    else $error("makespan nonzero before the last result");

  a_busy_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start) && $past(cmd.command) == CMD_RUN)
    else $error("busy raised without a run transaction");

endmodule

@@ tb/sv/blocking_flowshop_pf_sequencer_tb.sv @@
// Testbench for the blocking flow-shop sequencer: loads and runs are queued,
// driven back to back or with random gaps, and every emitted sequence entry is checked against
// a local profile-fitting model. Depends on bfs_pkg and the sequencer RTL.
`timescale 1ns / 100ps

module blocking_flowshop_pf_sequencer_tb;
  import bfs_pkg::*;

  localparam int NJ = DEF_MAX_JOBS;
  localparam int NM = DEF_MAX_MACHINES;
  localparam int STALL_LIMIT = 50000;
  localparam int SETTLE = 40;
  localparam int FILL_JOBS = 5;
  localparam int FILL_MACHINES = 8;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_B = 2'd3;

  typedef longint unsigned row_t [NM+1];

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic busy;
  logic result_valid;
  rsp_t result;

  bit [15:0] proc_tbl [NJ][NM];
  int unsigned job_cnt_reg = NJ;
  int unsigned mach_cnt_reg = NM;
  cmd_t pending_cmds[$];
  rsp_t seq_expect[$];
  int unsigned wait_left = 0;
  bit no_gaps = 1'b0;
  int errors = 0;
  int stall_cycles = 0;

  blocking_flowshop_pf_sequencer u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .result(result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic row_t extend_row(row_t d, int unsigned j, int unsigned m);
    row_t c;
    longint unsigned a;
    c = d;
    c[0] = d[1];
    for (int unsigned k = 1; k < m; k++) begin
      a = c[k-1] + 64'(proc_tbl[j][k-1]);
      c[k] = (a > d[k+1]) ? a : d[k+1];
    end
    c[m] = c[m-1] + 64'(proc_tbl[j][m-1]);
    return c;
  endfunction

  task automatic plan_run(input cmd_t c);
    int unsigned n, m, first, bj;
    longint unsigned best, t, sigma, bsig, span;
    bit [NJ-1:0] mask;
    row_t dep, cand;
    rsp_t rs[$];
    rsp_t r;
    n = (job_cnt_reg == 0) ? 1 : (job_cnt_reg > NJ) ? NJ : job_cnt_reg;
    m = (mach_cnt_reg == 0) ? 1 : (mach_cnt_reg > NM) ? NM : mach_cnt_reg;
    first = 32'(c.start_job);
    if (!c.use_start_job || first >= n) begin
      best = '1;
      first = 0;
      for (int unsigned j = 0; j < n; j++) begin
        t = 0;
        for (int unsigned k = 0; k < m; k++) t += 64'(proc_tbl[j][k]);
        if (t < best) begin
          best = t;
          first = j;
        end
      end
    end
    mask = '0;
    mask[first] = 1'b1;
    foreach (dep[k]) dep[k] = 0;
    for (int unsigned k = 1; k <= m; k++) dep[k] = dep[k-1] + 64'(proc_tbl[first][k-1]);
    r = '0;
    r.job = first[4:0];
    rs = {rs, r};
    for (int unsigned pos = 1; pos < n; pos++) begin
      bsig = '1;
      bj = 0;
      for (int unsigned j = 0; j < n; j++) begin
        if (mask[j]) continue;
        cand = extend_row(dep, j, m);
        sigma = 0;
        for (int unsigned k = 1; k <= m; k++)
          sigma += cand[k] - (dep[k] + 64'(proc_tbl[j][k-1]));
        if (sigma < bsig) begin
          bsig = sigma;
          bj = j;
        end
      end
      dep = extend_row(dep, bj, m);
      mask[bj] = 1'b1;
      r = '0;
      r.position = pos[4:0];
      r.job = bj[4:0];
      rs = {rs, r};
    end
    span = dep[m];
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    rs[n-1].makespan = span[31:0];
    rs[n-1].last = 1'b1;
    seq_expect = {seq_expect, rs};
  endtask

  always @(posedge clk) begin
    bit fire;
    cmd_t nxt;
    if (!rst) begin
      fire = start && !busy;
      if (fire) begin
        if (cmd.command == CMD_LOAD)
          proc_tbl[cmd.job_index][cmd.machine_index] = cmd.proc_time;
        else
          plan_run(cmd);
        wait_left = no_gaps ? 0 : $urandom_range(0, 11);
      end
      if (!start || fire) begin
        if (wait_left > 0) begin
          wait_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          nxt = pending_cmds.pop_front();
          cmd <= nxt;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    rsp_t w;
    if (!rst && result_valid) begin
      if (seq_expect.size() == 0) begin
        report("unexpected transaction", result.job, -1);
      end else begin
        w = seq_expect.pop_front();
        if (result.position !== w.position) report("position", result.position, w.position);
        if (result.job !== w.job) report("job", result.job, w.job);
        if (result.makespan !== w.makespan) report("makespan", result.makespan, w.makespan);
        if (result.last !== w.last) report("last", result.last, w.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[blocking_flowshop_pf_sequencer] ERROR");
      $finish;
    end
  end

  function automatic cmd_t mk_load(int unsigned j, int unsigned k, int unsigned v);
    cmd_t c;
    c = '0;
    c.command = CMD_LOAD;
    c.job_index = j[4:0];
    c.machine_index = k[3:0];
    c.proc_time = v[15:0];
    c.use_start_job = 1'($urandom_range(0, 1));
    c.start_job = 5'($urandom_range(0, 31));
    return c;
  endfunction

  function automatic cmd_t mk_run(bit use_sj, int unsigned sj);
    cmd_t c;
    c = $urandom();
    c.command = CMD_RUN;
    c.use_start_job = use_sj;
    c.start_job = sj[4:0];
    return c;
  endfunction

  task automatic drain();
    wait (pending_cmds.size() == 0 && !start && seq_expect.size() == 0 && !busy);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_BITS-1:0];
    if (idx == REG_JOB_COUNT) job_cnt_reg = val & 6'h3F;
    else if (idx == REG_MACHINE_COUNT) mach_cnt_reg = val & 5'h1F;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_counts(input int unsigned n, input int unsigned m);
    write_reg(REG_JOB_COUNT, n);
    write_reg(REG_MACHINE_COUNT, m);
  endtask

  task automatic random_phase(input int unsigned items);
    int unsigned n;
    n = (job_cnt_reg == 0) ? 1 : (job_cnt_reg > NJ) ? NJ : job_cnt_reg;
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 9) < 4)
        pending_cmds = {pending_cmds, mk_run(1'($urandom_range(0, 1)),
                                             $urandom_range(0, n + 2))};
      else
        pending_cmds = {pending_cmds, mk_load($urandom_range(0, 31), $urandom_range(0, 15),
                                              ($urandom_range(0, 5) == 0) ? 32'hFFFF :
                                              $urandom_range(0, 65535))};
    end
    drain();
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Runs only read the filled corner of the table and the two long rows,
    // so no run ever reads an unwritten entry.
    set_counts(FILL_JOBS, FILL_MACHINES);
    no_gaps = 1'b1;
    for (int j = 0; j < FILL_JOBS; j++)
      for (int k = 0; k < FILL_MACHINES; k++)
        pending_cmds = {pending_cmds, mk_load(j, k, $urandom_range(0, 65535))};
    for (int j = 0; j < 2; j++)
      for (int k = FILL_MACHINES; k < NM; k++)
        pending_cmds = {pending_cmds, mk_load(j, k, $urandom_range(0, 65535))};
    drain();
    no_gaps = 1'b0;

    pending_cmds = {pending_cmds, mk_run(1'b0, 0)};
    pending_cmds = {pending_cmds, mk_run(1'b1, 31)};
    pending_cmds = {pending_cmds, mk_run(1'b1, 3)};
    drain();

    set_counts(4, 3);
    for (int j = 0; j < 4; j++)
      for (int k = 0; k < 3; k++)
        pending_cmds = {pending_cmds, mk_load(j, k, 0)};
    pending_cmds = {pending_cmds, mk_run(1'b0, 0)};
    pending_cmds = {pending_cmds, mk_run(1'b1, 2)};
    pending_cmds = {pending_cmds, mk_load(2, 1, 16'hFFFF)};
    pending_cmds = {pending_cmds, mk_load(3, 0, 16'hFFFF)};
    pending_cmds = {pending_cmds, mk_run(1'b1, 0)};
    pending_cmds = {pending_cmds, mk_run(1'b1, 4)};
    pending_cmds = {pending_cmds, mk_run(1'b0, 31)};
    drain();

    set_counts(0, 0);
    pending_cmds = {pending_cmds, mk_run(1'b1, 0)};
    pending_cmds = {pending_cmds, mk_run(1'b1, 1)};
    drain();
    set_counts(1, 1);
    pending_cmds = {pending_cmds, mk_run(1'b0, 0)};
    drain();
    set_counts(FILL_JOBS, FILL_MACHINES);
    write_reg(REG_UNUSED_A, 5);
    write_reg(REG_UNUSED_B, 42);
    pending_cmds = {pending_cmds, mk_run(1'b1, 17)};
    drain();
    set_counts(2, 31);
    pending_cmds = {pending_cmds, mk_run(1'b1, 1)};
    drain();

    set_counts(5, 4);
    random_phase(8);
    set_counts(2, 1);
    random_phase(6);
    set_counts($urandom_range(1, FILL_JOBS), $urandom_range(1, FILL_MACHINES));
    random_phase(8);

    if (errors == 0) begin
      $display("[blocking_flowshop_pf_sequencer] OK");
    end else begin
      $display("[blocking_flowshop_pf_sequencer] ERROR");
    end
    $finish;
  end

endmodule
